// ===== design/tcd_pkg.sv =====
// tcd_pkg: shared constants, codes and types of the text charset detector
// no dependencies; compiled before all other design files
package tcd_pkg;

  localparam int MAX_BYTES = 1024;
  localparam int POS_W     = $clog2(MAX_BYTES + 1);
  localparam int HDR_LEN   = 3;
  localparam int WIN_LEN   = 4;

  localparam logic [7:0] BOM8_B0   = 8'd239;
  localparam logic [7:0] BOM8_B1   = 8'd187;
  localparam logic [7:0] BOM8_B2   = 8'd191;
  localparam logic [7:0] BOM16_FE  = 8'd254;
  localparam logic [7:0] BOM16_FF  = 8'd255;

  localparam logic [7:0] LIM_TAIL  = 8'h80;
  localparam logic [7:0] LIM_LEAD2 = 8'hc0;
  localparam logic [7:0] LIM_LEAD3 = 8'he0;
  localparam logic [7:0] LIM_LEAD4 = 8'hf0;
  localparam logic [7:0] LIM_END   = 8'hf8;

  typedef enum logic [1:0] {
    ENC_BINARY  = 2'd0,
    ENC_UTF8    = 2'd1,
    ENC_UTF16LE = 2'd2,
    ENC_UTF16BE = 2'd3
  } enc_t;

  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_UTF16 = 2'd2;
  localparam logic [1:0] SKIP_UTF8  = 2'd3;

  typedef logic [POS_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t pos;
    cnt_t zero_total;
    cnt_t even_hits;
    cnt_t odd_hits;
    cnt_t utf8_hits;
    logic utf8_invalid;
    logic ascii_invalid;
  } score_t;

  typedef struct packed {
    score_t                    score;
    logic [HDR_LEN-1:0][7:0]   hdr;
  } stats_t;

endpackage

// ===== design/tcd_if.sv =====
// tcd_byte_if and tcd_result_if: valid/ready channels of the charset detector
// no dependency on tcd_pkg; the result field widths are written out in the interface
interface tcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, byte_value, last, input ready);
  modport sink   (input valid, byte_value, last, output ready);
endinterface

interface tcd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoding;
  logic [1:0] bom_skip;

  modport source (output valid, encoding, bom_skip, input ready);
  modport sink   (input valid, encoding, bom_skip, output ready);
endinterface

// ===== design/tcd_score.sv =====
// tcd_score: byte window, header capture and scoring counters
// depends on tcd_pkg for the limit, thresholds and the stats types
module tcd_score (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            clear,
  input  logic [7:0]      byte_value,
  output tcd_pkg::stats_t stats_nxt
);

  tcd_pkg::score_t                          score_r;
  tcd_pkg::score_t                          score_nxt;
  logic [tcd_pkg::HDR_LEN-1:0][7:0]         hdr_r;
  logic [tcd_pkg::HDR_LEN-1:0][7:0]         hdr_nxt;
  logic [tcd_pkg::WIN_LEN-1:0][7:0]         win_r;
  logic [tcd_pkg::WIN_LEN-1:0][7:0]         win_nxt;

  logic [7:0] c;
  logic [7:0] n1;
  logic [7:0] n2;
  logic [7:0] n3;
  logic       even;
  logic       is_ascii;
  logic       hit;
  logic       bad;

  function automatic logic is_tail(input logic [7:0] b);
    return (b >= tcd_pkg::LIM_TAIL) && (b < tcd_pkg::LIM_LEAD2);
  endfunction

  assign c    = win_r[0];
  assign n1   = win_r[1];
  assign n2   = win_r[2];
  assign n3   = win_r[3];
  assign even = ~score_r.pos[0];
  assign is_ascii = c < tcd_pkg::LIM_TAIL;

  // utf-8 classification of the oldest window byte
  always_comb begin
    hit = 1'b0;
    bad = 1'b0;
    if (is_tail(c)) begin
      hit = 1'b0;
    end else if (is_ascii) begin
      hit = 1'b1;
    end else if (c >= tcd_pkg::LIM_LEAD2 && c < tcd_pkg::LIM_LEAD3 && is_tail(n1)) begin
      hit = 1'b1;
    end else if (c >= tcd_pkg::LIM_LEAD3 && c < tcd_pkg::LIM_LEAD4 &&
                 is_tail(n1) && is_tail(n2)) begin
      hit = 1'b1;
    end else if (c >= tcd_pkg::LIM_LEAD4 && c < tcd_pkg::LIM_END &&
                 is_tail(n1) && is_tail(n2) && is_tail(n3)) begin
      hit = 1'b1;
    end else begin
      bad = 1'b1;
    end
  end

  always_comb begin
    score_nxt = score_r;
    hdr_nxt   = hdr_r;
    win_nxt   = win_r;
    if (score_r.pos < tcd_pkg::POS_W'(tcd_pkg::MAX_BYTES)) begin
      if (score_r.pos < tcd_pkg::POS_W'(tcd_pkg::HDR_LEN)) begin
        hdr_nxt[score_r.pos[1:0]] = byte_value;
      end
      if (score_r.pos >= tcd_pkg::POS_W'(tcd_pkg::WIN_LEN)) begin
        score_nxt.zero_total = score_r.zero_total + tcd_pkg::POS_W'(c == 8'd0);
        score_nxt.ascii_invalid = score_r.ascii_invalid | ~is_ascii;
        if (even) begin
          score_nxt.even_hits = score_r.even_hits + tcd_pkg::POS_W'(c == 8'd0);
          score_nxt.odd_hits  = score_r.odd_hits + tcd_pkg::POS_W'(n1 == 8'd0);
        end
        score_nxt.utf8_hits    = score_r.utf8_hits + tcd_pkg::POS_W'(hit);
        score_nxt.utf8_invalid = score_r.utf8_invalid | bad;
      end
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = win_r[3];
      win_nxt[3] = byte_value;
      score_nxt.pos = score_r.pos + tcd_pkg::POS_W'(1);
    end
  end

  assign stats_nxt.score = score_nxt;
  assign stats_nxt.hdr   = hdr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else if (step) begin
      if (clear) begin
        score_r <= '0;
      end else begin
        score_r <= score_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hdr_r <= hdr_nxt;
      win_r <= win_nxt;
    end
  end

endmodule

// ===== design/tcd_decide.sv =====
// tcd_decide: bom match and priority rule that picks the encoding
// depends on tcd_pkg for the bom bytes, codes and the stats type
module tcd_decide (
  input  tcd_pkg::stats_t stats,
  output tcd_pkg::enc_t   enc,
  output logic [1:0]      bom_skip
);

  logic bom8;
  logic bom16be;
  logic bom16le;
  logic few_zeros;
  logic scored;
  logic u8_ok;

  assign bom8 = (stats.score.pos >= tcd_pkg::POS_W'(3)) &&
                stats.hdr[0] == tcd_pkg::BOM8_B0 &&
                stats.hdr[1] == tcd_pkg::BOM8_B1 &&
                stats.hdr[2] == tcd_pkg::BOM8_B2;
  assign bom16be = (stats.score.pos >= tcd_pkg::POS_W'(2)) &&
                   stats.hdr[0] == tcd_pkg::BOM16_FE && stats.hdr[1] == tcd_pkg::BOM16_FF;
  assign bom16le = (stats.score.pos >= tcd_pkg::POS_W'(2)) &&
                   stats.hdr[0] == tcd_pkg::BOM16_FF && stats.hdr[1] == tcd_pkg::BOM16_FE;

  assign few_zeros = stats.score.zero_total <= tcd_pkg::POS_W'(1);
  assign scored    = stats.score.pos > tcd_pkg::POS_W'(tcd_pkg::WIN_LEN);
  assign u8_ok     = ~stats.score.utf8_invalid && (stats.score.utf8_hits != '0);

  always_comb begin
    bom_skip = tcd_pkg::SKIP_NONE;
    enc      = tcd_pkg::ENC_BINARY;
    if (bom8) begin
      enc      = tcd_pkg::ENC_UTF8;
      bom_skip = tcd_pkg::SKIP_UTF8;
    end else if (bom16be) begin
      enc      = tcd_pkg::ENC_UTF16BE;
      bom_skip = tcd_pkg::SKIP_UTF16;
    end else if (bom16le) begin
      enc      = tcd_pkg::ENC_UTF16LE;
      bom_skip = tcd_pkg::SKIP_UTF16;
    end else if (~stats.score.ascii_invalid && scored && few_zeros) begin
      enc = tcd_pkg::ENC_UTF8;
    end else if (u8_ok && few_zeros) begin
      enc = tcd_pkg::ENC_UTF8;
    end else if (stats.score.even_hits != '0 &&
                 stats.score.even_hits > stats.score.odd_hits) begin
      enc = tcd_pkg::ENC_UTF16BE;
    end else if (stats.score.odd_hits != '0 &&
                 stats.score.odd_hits >= stats.score.even_hits) begin
      enc = tcd_pkg::ENC_UTF16LE;
    end else if (u8_ok) begin
      enc = tcd_pkg::ENC_UTF8;
    end else begin
      enc = tcd_pkg::ENC_BINARY;
    end
  end

endmodule

// ===== design/text_charset_detector.sv =====
// text_charset_detector: top level, input register, scoring and result register
// depends on tcd_pkg, tcd_if, tcd_score and tcd_decide
//
// usage
//   in_chan carries one byte of the file head per request, in file order, with
//   last set on the final byte. bytes past tcd_pkg::MAX_BYTES score nothing.
//   out_chan carries one request per stream: the encoding code and the count
//   of byte order mark bytes to skip. streams follow each other with no gap.
// throughput and order
//   one byte per cycle sustained while no last byte waits on a held result.
//   a last byte is scored and decided while it sits in the input register,
//   and the result register loads from that once it is free. the scoring
//   counters take each byte from a four-byte window.
// reset
//   rst_n clears the input and result valid bits and all counters and flags.
// stall
//   a held result keeps the result register; bytes that end no stream still
//   move through. a last byte waits in the input register until the result
//   register is free, and in_chan.ready drops only then.
module text_charset_detector (
  input  logic                clk,
  input  logic                rst_n,
  tcd_byte_if.sink            in_chan,
  tcd_result_if.source        out_chan
);

  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  in_last_r;
  logic                  out_v_r;
  logic [1:0]            out_enc_r;
  logic [1:0]            out_skip_r;
  logic                  adv;
  logic                  out_free;
  tcd_pkg::stats_t       stats_nxt;
  tcd_pkg::enc_t         enc;
  logic [1:0]            bom_skip;

  assign out_free     = ~out_v_r | out_chan.ready;
  assign adv          = in_v_r & (~in_last_r | out_free);
  assign in_chan.ready = ~in_v_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.byte_value;
      in_last_r <= in_chan.last;
    end
  end

  tcd_score u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .clear      (in_last_r),
    .byte_value (in_byte_r),
    .stats_nxt  (stats_nxt)
  );

  tcd_decide u_decide (
    .stats    (stats_nxt),
    .enc      (enc),
    .bom_skip (bom_skip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= adv & in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adv && in_last_r) begin
      out_enc_r  <= enc;
      out_skip_r <= bom_skip;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.encoding = out_enc_r;
  assign out_chan.bom_skip = out_skip_r;

endmodule

// ===== design/tcd_checker.sv =====
// tcd_checker: port-level checks of the charset detector, bound to the top level
// depends on tcd_pkg for the encoding and skip codes
module tcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] encoding,
  input logic [1:0] bom_skip
);

  // no result survives reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result is held unchanged while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(encoding) && $stable(bom_skip))
    else $error("stalled result changed");

  // a last byte yields a result once the output side is free
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("missing result after last byte");

  // a utf-8 mark is only reported with utf-8
  a_skip_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bom_skip == tcd_pkg::SKIP_UTF8 |-> encoding == tcd_pkg::ENC_UTF8)
    else $error("utf-8 mark with wrong encoding");

  // a utf-16 mark is only reported with utf-16, and no skip count of one
  a_skip_utf16: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bom_skip != tcd_pkg::SKIP_UTF8 && bom_skip != tcd_pkg::SKIP_NONE |->
      bom_skip == tcd_pkg::SKIP_UTF16 &&
      (encoding == tcd_pkg::ENC_UTF16LE || encoding == tcd_pkg::ENC_UTF16BE))
    else $error("bad utf-16 mark result");

endmodule

bind text_charset_detector tcd_checker u_tcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_last   (in_chan.last),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .encoding  (out_chan.encoding),
  .bom_skip  (out_chan.bom_skip)
);
